// ----- hw/rtl/two_level_collation_compare_top_defines.svh -----
// ---------------------------------------------------------------------------
// two_level_collation_compare_top_defines
// assertion macros shared by the collation compare rtl
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_COLLATION_COMPARE_TOP_DEFINES_SVH
`define TWO_LEVEL_COLLATION_COMPARE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define TLCC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tlcc assertion failed");

// condition must never be seen outside reset
`define TLCC_NEVER(lbl, clk, rst, cond) \
   `TLCC_ASSERT(lbl, clk, rst, !(cond))

`else

`define TLCC_ASSERT(lbl, clk, rst, prop)
`define TLCC_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- hw/rtl/tlcc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlcc_pkg
// types, order codes and weight tables for the two-level collation compare
// ---------------------------------------------------------------------------
package tlcc_pkg;

   // order codes
   typedef enum logic [1:0] {
      ORD_EQUAL       = 2'd0,
      ORD_LEFT_FIRST  = 2'd1,
      ORD_RIGHT_FIRST = 2'd2
   } order_type;

   localparam int unsigned WEIGHT_W = 6;

   typedef logic [WEIGHT_W-1:0] weight_type;

   // primary and secondary weight of one byte
   typedef struct packed {
      weight_type pri;
      weight_type sec;
   } weight_pair_type;

   // per-position flags that travel with a character pair
   typedef struct packed {
      logic left_present;
      logic right_present;
      logic final_pair;
   } pair_flags_type;

   // ascii upper case folds to lower case, markers and latin-2 listed
   function automatic weight_pair_type weights_of(input logic [7:0] code);
      logic [7:0]      lc;
      weight_pair_type w;
      lc = code;
      if (code >= 8'h41 && code <= 8'h5A) begin
         lc = code + 8'h20;
      end
      case (lc)
         8'h23, 8'h40, 8'h26: w = '{6'd10, 6'd14};
         8'h30: w = '{6'd32, 6'd43};
         8'h31: w = '{6'd33, 6'd44};
         8'h32: w = '{6'd34, 6'd45};
         8'h33: w = '{6'd35, 6'd46};
         8'h34: w = '{6'd36, 6'd47};
         8'h35: w = '{6'd37, 6'd48};
         8'h36: w = '{6'd38, 6'd49};
         8'h37: w = '{6'd39, 6'd50};
         8'h38: w = '{6'd40, 6'd51};
         8'h39: w = '{6'd41, 6'd52};
         8'h61: w = '{6'd1, 6'd1};
         8'h62: w = '{6'd2, 6'd3};
         8'h63: w = '{6'd3, 6'd4};
         8'h64: w = '{6'd5, 6'd6};
         8'h65: w = '{6'd6, 6'd8};
         8'h66: w = '{6'd7, 6'd11};
         8'h67: w = '{6'd8, 6'd12};
         8'h68: w = '{6'd9, 6'd13};
         8'h69: w = '{6'd11, 6'd15};
         8'h6A: w = '{6'd12, 6'd17};
         8'h6B: w = '{6'd13, 6'd18};
         8'h6C: w = '{6'd14, 6'd19};
         8'h6D: w = '{6'd15, 6'd20};
         8'h6E: w = '{6'd16, 6'd21};
         8'h6F: w = '{6'd17, 6'd23};
         8'h70: w = '{6'd18, 6'd25};
         8'h71: w = '{6'd19, 6'd26};
         8'h72: w = '{6'd20, 6'd27};
         8'h73: w = '{6'd22, 6'd29};
         8'h74: w = '{6'd24, 6'd31};
         8'h75: w = '{6'd25, 6'd33};
         8'h76: w = '{6'd26, 6'd36};
         8'h77: w = '{6'd27, 6'd37};
         8'h78: w = '{6'd28, 6'd38};
         8'h79: w = '{6'd29, 6'd39};
         8'h7A: w = '{6'd30, 6'd41};
         8'hE1, 8'hC1: w = '{6'd1, 6'd2};
         8'hE8, 8'hC8: w = '{6'd4, 6'd5};
         8'hEF, 8'hCF: w = '{6'd5, 6'd7};
         8'hE9, 8'hC9: w = '{6'd6, 6'd9};
         8'hEC, 8'hCC: w = '{6'd6, 6'd10};
         8'hED, 8'hCD: w = '{6'd11, 6'd16};
         8'hF2, 8'hD2: w = '{6'd16, 6'd22};
         8'hF3, 8'hD3: w = '{6'd17, 6'd24};
         8'hF8, 8'hD8: w = '{6'd21, 6'd28};
         8'hB9, 8'hA9: w = '{6'd23, 6'd30};
         8'hBB, 8'hAB: w = '{6'd24, 6'd32};
         8'hFA, 8'hDA: w = '{6'd25, 6'd34};
         8'hF9, 8'hD9: w = '{6'd25, 6'd35};
         8'hFD, 8'hDD: w = '{6'd29, 6'd40};
         8'hBE, 8'hAE: w = '{6'd31, 6'd42};
         default: w = '{6'd0, 6'd0};
      endcase
      return w;
   endfunction

   // three-way compare of two weights
   function automatic order_type weigh(input weight_type wl, input weight_type wr);
      order_type o;
      if (wl < wr) begin
         o = ORD_LEFT_FIRST;
      end else if (wl > wr) begin
         o = ORD_RIGHT_FIRST;
      end else begin
         o = ORD_EQUAL;
      end
      return o;
   endfunction

endpackage

// ----- hw/rtl/tlcc_weight_rom.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlcc_weight_rom
// dual-read synchronous weight rom with registered read data, with the
// stage register that carries the pair flags alongside the read data
// ---------------------------------------------------------------------------
module tlcc_weight_rom (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [7:0]              left_char,
   input  logic [7:0]              right_char,
   input  tlcc_pkg::pair_flags_type in_flags,
   output logic                    s1_valid,
   output tlcc_pkg::weight_pair_type left_weight,
   output tlcc_pkg::weight_pair_type right_weight,
   output tlcc_pkg::pair_flags_type s1_flags
);
   import tlcc_pkg::*;

   logic            s1_valid_ff;
   weight_pair_type left_weight_ff;
   weight_pair_type right_weight_ff;
   pair_flags_type  s1_flags_ff;

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   // rom read ports, registered data
   always_ff @(posedge clock) begin
      if (advance) begin
         left_weight_ff  <= weights_of(left_char);
         right_weight_ff <= weights_of(right_char);
         s1_flags_ff     <= in_flags;
      end
   end

   assign s1_valid     = s1_valid_ff;
   assign left_weight  = left_weight_ff;
   assign right_weight = right_weight_ff;
   assign s1_flags     = s1_flags_ff;

endmodule

// ----- hw/rtl/tlcc_verdict.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlcc_verdict
// read-modify-write of the verdict state and final order decision
// ---------------------------------------------------------------------------
`include "two_level_collation_compare_top_defines.svh"

module tlcc_verdict (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      s1_fire,
   input  tlcc_pkg::weight_pair_type left_weight,
   input  tlcc_pkg::weight_pair_type right_weight,
   input  tlcc_pkg::pair_flags_type  s1_flags,
   output logic                      order_valid,
   output tlcc_pkg::order_type       order
);
   import tlcc_pkg::*;

   order_type pri_ff, pri_in;
   order_type sec_ff, sec_in;
   order_type len_ff, len_in;
   logic      both_present;

   assign both_present = s1_flags.left_present && s1_flags.right_present;

   // next verdict state
   always_comb begin
      pri_in = pri_ff;
      sec_in = sec_ff;
      len_in = len_ff;
      if (len_ff == ORD_EQUAL) begin
         if (both_present) begin
            if (pri_ff == ORD_EQUAL) begin
               pri_in = weigh(left_weight.pri, right_weight.pri);
            end
            if (sec_ff == ORD_EQUAL) begin
               sec_in = weigh(left_weight.sec, right_weight.sec);
            end
         end else if (s1_flags.left_present) begin
            len_in = ORD_RIGHT_FIRST;
         end else if (s1_flags.right_present) begin
            len_in = ORD_LEFT_FIRST;
         end
      end
   end

   // final order: primary, then length, then secondary
   always_comb begin
      order_valid = s1_fire && s1_flags.final_pair;
      if (pri_in != ORD_EQUAL) begin
         order = pri_in;
      end else if (len_in != ORD_EQUAL) begin
         order = len_in;
      end else begin
         order = sec_in;
      end
   end

   // state update, cleared after a final pair
   always_ff @(posedge clock) begin
      if (reset) begin
         pri_ff <= ORD_EQUAL;
         sec_ff <= ORD_EQUAL;
         len_ff <= ORD_EQUAL;
      end else if (s1_fire) begin
         if (s1_flags.final_pair) begin
            pri_ff <= ORD_EQUAL;
            sec_ff <= ORD_EQUAL;
            len_ff <= ORD_EQUAL;
         end else begin
            pri_ff <= pri_in;
            sec_ff <= sec_in;
            len_ff <= len_in;
         end
      end
   end

   `TLCC_ASSERT(a_clear_after_final, clock, reset, (s1_fire && s1_flags.final_pair) |=> (pri_ff == ORD_EQUAL && sec_ff == ORD_EQUAL && len_ff == ORD_EQUAL))
   `TLCC_ASSERT(a_primary_sticky, clock, reset, (s1_fire && !s1_flags.final_pair && pri_ff != ORD_EQUAL) |=> $stable(pri_ff))
   `TLCC_ASSERT(a_length_freezes, clock, reset, (s1_fire && !s1_flags.final_pair && len_ff != ORD_EQUAL) |=> ($stable(pri_ff) && $stable(sec_ff) && $stable(len_ff)))

endmodule

// ----- hw/rtl/tlcc_rsp_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlcc_rsp_queue
// two-entry result queue that decouples the verdict stage from rsp ready
// ---------------------------------------------------------------------------
`include "two_level_collation_compare_top_defines.svh"

module tlcc_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  tlcc_pkg::order_type wr_order,
   output logic                full,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output tlcc_pkg::order_type rsp_order
);
   import tlcc_pkg::*;

   order_type  entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_en;

   assign rd_en      = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign full       = (cnt_ff == 2'd2);
   assign rsp_order  = entry_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (wr_en) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (rd_en) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_order;
      end
   end

   `TLCC_NEVER(a_no_overflow, clock, reset, wr_en && full)
   `TLCC_NEVER(a_count_range, clock, reset, cnt_ff == 2'd3)
   `TLCC_ASSERT(a_count_tracks, clock, reset, (wr_en && !rd_en) |=> (cnt_ff == $past(cnt_ff) + 2'd1))

endmodule

// ----- hw/rtl/two_level_collation_compare_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_level_collation_compare_top
// czech two-level collation compare of two latin-2 strings, outside stalls one pair a cycle
// ---------------------------------------------------------------------------
// Takes one character pair per transaction and, while not stalled, one pair
// per clock. Each pair goes through two stages: the weight rom read (both
// strings looked up in parallel) and the verdict update, which reads and
// rewrites the verdict state in the same cycle, so back-to-back pairs need
// no interlock. A final pair passes the rom stage register, then the order
// code of its string pair is written to the result queue, raising rsp_tvalid; a
// two-entry queue holds results while rsp_tready is low, and input stalls
// only while that queue is full and a final pair waits in the verdict stage.
// Order codes: 0 equal, 1 first string earlier, 2 second string earlier.
// ---------------------------------------------------------------------------
module two_level_collation_compare_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] left_char, [15:8] right_char
   input  logic [1:0]  req_tuser,   // [0] left_present, [1] right_present
   input  logic        req_tlast,   // final_pair
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] order, [7:2] zero
);
   import tlcc_pkg::*;

   pair_flags_type  in_flags;
   pair_flags_type  s1_flags;
   weight_pair_type left_weight;
   weight_pair_type right_weight;
   logic            s1_valid;
   logic            advance;
   logic            s1_fire;
   logic            q_full;
   logic            order_valid;
   order_type       order;
   order_type       rsp_order;

   assign in_flags.left_present  = req_tuser[0];
   assign in_flags.right_present = req_tuser[1];
   assign in_flags.final_pair    = req_tlast;

   // pipeline moves unless a result is due and the queue is full
   assign advance    = !s1_valid || !s1_flags.final_pair || !q_full;
   assign s1_fire    = s1_valid && advance;
   assign req_tready = advance;

   tlcc_weight_rom u_weight_rom (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_tvalid),
      .left_char    (req_tdata[7:0]),
      .right_char   (req_tdata[15:8]),
      .in_flags     (in_flags),
      .s1_valid     (s1_valid),
      .left_weight  (left_weight),
      .right_weight (right_weight),
      .s1_flags     (s1_flags)
   );

   tlcc_verdict u_verdict (
      .clock        (clock),
      .reset        (reset),
      .s1_fire      (s1_fire),
      .left_weight  (left_weight),
      .right_weight (right_weight),
      .s1_flags     (s1_flags),
      .order_valid  (order_valid),
      .order        (order)
   );

   tlcc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (order_valid),
      .wr_order   (order),
      .full       (q_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_order  (rsp_order)
   );

   assign rsp_tdata = {6'd0, rsp_order};

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// stand-alone testbench for the two-level collation compare
// ---------------------------------------------------------------------------
// Feeds character pairs of two latin-2 strings through the request stream and
// predicts each order code with an independent collation model built from
// its own primary and secondary weight tables. Every response is checked
// against the oldest predicted order. Directed string pairs hit the special
// cases; random string pairs, mostly near-copies of each other, drive the
// compare deep into the secondary level, mixed with random noise pairs.
// The sender bursts with random gaps and the receiver stalls on its own.
// ---------------------------------------------------------------------------
module tb_top;
   import tlcc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PAIR_TARGET = 1350;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] left_char, [15:8] right_char
   logic [1:0]  req_tuser = '0;   // [0] left_present, [1] right_present
   logic        req_tlast = 1'b0; // final_pair
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [1:0] order, [7:2] zero

   // collation model state and weights
   weight_type  pri_w [256];
   weight_type  sec_w [256];
   logic [7:0]  weighed_codes [$];
   order_type   pri_verdict = ORD_EQUAL;
   order_type   sec_verdict = ORD_EQUAL;
   order_type   len_verdict = ORD_EQUAL;
   order_type   expected_orders [$];
   order_type   want_order;

   logic [7:0]  left_text [$];
   logic [7:0]  right_text [$];

   int          pairs_sent = 0;
   int          burst_left = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          rsp_mode = 0;
   int          rsp_mode_left = 0;

   two_level_collation_compare_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stall pattern: always ready, coin flip, or mostly stalled
   always @(posedge clock) begin
      if (rsp_mode_left == 0) begin
         rsp_mode      <= $urandom_range(0, 2);
         rsp_mode_left <= $urandom_range(40, 300);
      end else begin
         rsp_mode_left <= rsp_mode_left - 1;
      end
      case (rsp_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 9) == 0);
         end
      endcase
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_orders.size() == 0) begin
            error_count++;
            $error("order: expected none, actual %0d", rsp_tdata[1:0]);
         end else begin
            want_order = expected_orders.pop_front();
            if (rsp_tdata[1:0] !== want_order) begin
               error_count++;
               $error("order: expected %0d, actual %0d", want_order, rsp_tdata[1:0]);
            end
            if (rsp_tdata[7:2] !== 6'd0) begin
               error_count++;
               $error("pad: expected 0, actual %0d", rsp_tdata[7:2]);
            end
         end
      end
   end

   function automatic void set_weight(input logic [7:0] code, input int p, input int s);
      pri_w[code] = weight_type'(p);
      sec_w[code] = weight_type'(s);
      weighed_codes.push_back(code);
   endfunction

   // weight tables: lower case ascii, digits, ch markers, latin-2 both cases
   function automatic void load_weights();
      for (int i = 0; i < 256; i++) begin
         pri_w[i] = '0;
         sec_w[i] = '0;
      end
      set_weight("#", 10, 14); set_weight("@", 10, 14); set_weight("&", 10, 14);
      for (int i = 0; i < 10; i++) begin
         set_weight(8'(8'h30 + i), 32 + i, 43 + i);
      end
      set_weight("a", 1, 1);   set_weight("b", 2, 3);   set_weight("c", 3, 4);
      set_weight("d", 5, 6);   set_weight("e", 6, 8);   set_weight("f", 7, 11);
      set_weight("g", 8, 12);  set_weight("h", 9, 13);  set_weight("i", 11, 15);
      set_weight("j", 12, 17); set_weight("k", 13, 18); set_weight("l", 14, 19);
      set_weight("m", 15, 20); set_weight("n", 16, 21); set_weight("o", 17, 23);
      set_weight("p", 18, 25); set_weight("q", 19, 26); set_weight("r", 20, 27);
      set_weight("s", 22, 29); set_weight("t", 24, 31); set_weight("u", 25, 33);
      set_weight("v", 26, 36); set_weight("w", 27, 37); set_weight("x", 28, 38);
      set_weight("y", 29, 39); set_weight("z", 30, 41);
      set_weight(8'hE1, 1, 2);   set_weight(8'hC1, 1, 2);
      set_weight(8'hE8, 4, 5);   set_weight(8'hC8, 4, 5);
      set_weight(8'hEF, 5, 7);   set_weight(8'hCF, 5, 7);
      set_weight(8'hE9, 6, 9);   set_weight(8'hC9, 6, 9);
      set_weight(8'hEC, 6, 10);  set_weight(8'hCC, 6, 10);
      set_weight(8'hED, 11, 16); set_weight(8'hCD, 11, 16);
      set_weight(8'hF2, 16, 22); set_weight(8'hD2, 16, 22);
      set_weight(8'hF3, 17, 24); set_weight(8'hD3, 17, 24);
      set_weight(8'hF8, 21, 28); set_weight(8'hD8, 21, 28);
      set_weight(8'hB9, 23, 30); set_weight(8'hA9, 23, 30);
      set_weight(8'hBB, 24, 32); set_weight(8'hAB, 24, 32);
      set_weight(8'hFA, 25, 34); set_weight(8'hDA, 25, 34);
      set_weight(8'hF9, 25, 35); set_weight(8'hD9, 25, 35);
      set_weight(8'hFD, 29, 40); set_weight(8'hDD, 29, 40);
      set_weight(8'hBE, 31, 42); set_weight(8'hAE, 31, 42);
   endfunction

   // only ascii upper case folds
   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

   function automatic order_type rank(input weight_type wl, input weight_type wr);
      if (wl < wr) return ORD_LEFT_FIRST;
      if (wl > wr) return ORD_RIGHT_FIRST;
      return ORD_EQUAL;
   endfunction

   // collation model: update verdicts for one pair, queue the order on a final pair
   function automatic void predict_order(input logic [7:0] lc, input logic [7:0] rc,
                                         input logic lp, input logic rp, input logic fin);
      logic [7:0] lk;
      logic [7:0] rk;
      lk = fold(lc);
      rk = fold(rc);
      if (len_verdict == ORD_EQUAL) begin
         if (lp && rp) begin
            if (pri_verdict == ORD_EQUAL) pri_verdict = rank(pri_w[lk], pri_w[rk]);
            if (sec_verdict == ORD_EQUAL) sec_verdict = rank(sec_w[lk], sec_w[rk]);
         end else if (lp) begin
            len_verdict = ORD_RIGHT_FIRST;
         end else if (rp) begin
            len_verdict = ORD_LEFT_FIRST;
         end
      end
      if (fin) begin
         if (pri_verdict != ORD_EQUAL) begin
            expected_orders.push_back(pri_verdict);
         end else if (len_verdict != ORD_EQUAL) begin
            expected_orders.push_back(len_verdict);
         end else begin
            expected_orders.push_back(sec_verdict);
         end
         pri_verdict = ORD_EQUAL;
         sec_verdict = ORD_EQUAL;
         len_verdict = ORD_EQUAL;
      end
   endfunction

   // one pair transaction, with burst and gap pacing in front of it
   task automatic send_pair(input logic [7:0] lc, input logic [7:0] rc,
                            input logic lp, input logic rp, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 1) ? $urandom_range(1, 5) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {rc, lc};
      req_tuser  <= {rp, lp};
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      predict_order(lc, rc, lp, rp, fin);
      if (lp || rp || fin) pairs_sent++;
   endtask

   // hold the request side idle until every predicted order has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_orders.size() != 0);
   endtask

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1: return 8'($urandom_range(0, 255));
         2: return 8'($urandom_range(8'h41, 8'h5A));
         default: return weighed_codes[$urandom_range(0, weighed_codes.size() - 1)];
      endcase
   endfunction

   // a character of equal primary weight: accent variant, other marker or case flip
   function automatic logic [7:0] twin_of(input logic [7:0] c);
      case (c)
         "a": return 8'hE1;
         8'hE1: return "a";
         "e": return 8'hE9;
         8'hE9: return 8'hEC;
         8'hEC: return "e";
         "u": return 8'hFA;
         8'hFA: return 8'hF9;
         8'hF9: return "u";
         "d": return 8'hEF;
         8'hEF: return "d";
         "i": return 8'hED;
         8'hED: return "i";
         "o": return 8'hF3;
         8'hF3: return "o";
         "#": return "@";
         "@": return "&";
         "&": return "#";
         default: begin
            if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
            if (c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
            return c;
         end
      endcase
   endfunction

   // build a string pair; the right one is mostly a near-copy of the left
   task automatic make_strings(input int min_len, input int max_len);
      int llen;
      int rlen;
      llen = $urandom_range(min_len, max_len);
      rlen = $urandom_range(0, 1) ? llen : $urandom_range(min_len, max_len);
      left_text.delete();
      right_text.delete();
      for (int i = 0; i < llen; i++) left_text.push_back(pick_char());
      for (int i = 0; i < rlen; i++) begin
         if (i >= llen) right_text.push_back(pick_char());
         else if ($urandom_range(0, 2) == 0) right_text.push_back(twin_of(left_text[i]));
         else right_text.push_back(left_text[i]);
      end
      if (rlen > 0 && $urandom_range(0, 3) == 0) begin
         right_text[$urandom_range(0, rlen - 1)] = pick_char();
      end
   endtask

   // stream the current string pair, final flag on the last position
   task automatic send_strings();
      int  span;
      logic lp;
      logic rp;
      span = (left_text.size() > right_text.size()) ? left_text.size() : right_text.size();
      if (span == 0) begin
         send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'b0, 1'b0, 1'b1);
      end
      for (int i = 0; i < span; i++) begin
         lp = (i < left_text.size());
         rp = (i < right_text.size());
         send_pair(lp ? left_text[i] : 8'($urandom_range(0, 255)),
                   rp ? right_text[i] : 8'($urandom_range(0, 255)),
                   lp, rp, i == span - 1);
      end
   endtask

   // byte extremes, case folding, ch markers, primary over secondary
   task automatic test_weight_extremes();
      send_pair(8'h00, 8'hFF, 1'b1, 1'b1, 1'b1);
      send_pair("A", "a", 1'b1, 1'b1, 1'b1);
      send_pair("#", "&", 1'b1, 1'b1, 1'b0);
      send_pair("@", "h", 1'b1, 1'b1, 1'b1);
      send_pair(8'hE1, "a", 1'b1, 1'b1, 1'b0);
      send_pair("b", "c", 1'b1, 1'b1, 1'b1);
      send_pair(8'hFF, "a", 1'b1, 1'b1, 1'b1);
      send_pair("z", 8'h00, 1'b1, 1'b1, 1'b1);
   endtask

   // presence differs, comparison stops after it, ignored and empty final pairs
   task automatic test_length_cases();
      send_pair("a", "a", 1'b1, 1'b1, 1'b0);
      send_pair("b", 8'h00, 1'b1, 1'b0, 1'b1);
      send_pair(8'h00, "x", 1'b0, 1'b1, 1'b0);
      send_pair("a", "z", 1'b1, 1'b1, 1'b1);
      send_pair("q", "q", 1'b0, 1'b0, 1'b0);
      send_pair("q", "q", 1'b1, 1'b1, 1'b0);
      send_pair(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
      send_pair(8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1);
      send_pair(8'h00, "m", 1'b1, 1'b0, 1'b0);
      send_pair(8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1);
   endtask

   // equal primaries: secondary weight decides, length before it where lengths differ
   task automatic test_secondary_cases();
      send_pair(8'hE9, 8'hEC, 1'b1, 1'b1, 1'b0);
      send_pair("o", "O", 1'b1, 1'b1, 1'b1);
      send_pair(8'hF9, 8'hFA, 1'b1, 1'b1, 1'b1);
      send_pair(8'hE1, "a", 1'b1, 1'b1, 1'b0);
      send_pair(8'h00, "m", 1'b0, 1'b1, 1'b1);
   endtask

   // random string pairs with noise pairs and broken sequences in between
   task automatic test_random_strings(input int target);
      while (pairs_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) == 0);
            end
         end else begin
            make_strings(0, 10);
            send_strings();
         end
      end
   endtask

   // long near-identical strings so the verdict falls late
   task automatic test_long_strings();
      repeat (6) begin
         make_strings(30, 48);
         send_strings();
      end
   endtask

   initial begin
      load_weights();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_weight_extremes();
      test_length_cases();
      test_secondary_cases();
      test_random_strings(PAIR_TARGET / 2);
      wait_drained();
      test_long_strings();
      test_random_strings(PAIR_TARGET);
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/tlcc_pkg.sv
hw/rtl/tlcc_weight_rom.sv
hw/rtl/tlcc_verdict.sv
hw/rtl/tlcc_rsp_queue.sv
hw/rtl/two_level_collation_compare_top.sv
dv/tb_top.sv
